[hw/rtl/mtep_pkg.sv]
// Shared types and constants for the MIDI track event parser.
package mtep_pkg;

    localparam int unsigned LimitWidth = 16;
    localparam logic [LimitWidth-1:0] EventLimitReset = 16'd1024;
    localparam logic [LimitWidth-1:0] CountOne = LimitWidth'(1);

    localparam logic [7:0] StatusFirst   = 8'h80;
    localparam logic [7:0] StatusOtherLo = 8'hA0;
    localparam logic [7:0] StatusSystem  = 8'hF0;
    localparam logic [7:0] StatusSysexEnd = 8'hF7;
    localparam logic [7:0] StatusMeta    = 8'hFF;
    localparam logic [3:0] NibbleNoteOff = 4'h8;
    localparam logic [3:0] NibbleProgram = 4'hC;
    localparam logic [3:0] NibblePress   = 4'hD;

    localparam logic EventNoteOn  = 1'b0;
    localparam logic EventNoteOff = 1'b1;

    typedef enum logic [6:0] {
        PH_DELTA  = 7'b0000001,
        PH_STATUS = 7'b0000010,
        PH_NOTE   = 7'b0000100,
        PH_VEL    = 7'b0001000,
        PH_MTYPE  = 7'b0010000,
        PH_LEN    = 7'b0100000,
        PH_SKIP   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic        event_kind;
        logic [3:0]  channel;
        logic [6:0]  note_number;
        logic [6:0]  velocity;
        logic [31:0] abs_time;
    } t_event;

endpackage

[hw/rtl/midi_track_event_parser.sv]
// MIDI track event parser: byte-wise track decoder emitting note events.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_stall  i_data_byte, i_last_byte
//   output    out        o_valid / i_stall  o_event_kind, o_channel, o_note_number,
//                                           o_velocity, o_abs_time
//   config    in         i_cfg_we           i_cfg_data (event limit)
//
// One byte is taken per cycle while o_stall is low; its state update and any note
// event are formed in the same cycle; the event is registered in the output buffer.
// A two-entry output buffer (result register plus skid register) absorbs a stalled
// output; o_stall rises only while both entries are full.
// Reset (synchronous, active low) clears the parser and sets the event limit to 1024.
module midi_track_event_parser #(
    parameter logic [mtep_pkg::LimitWidth-1:0] EVENT_LIMIT_RESET = mtep_pkg::EventLimitReset
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_event_kind,
    output logic [3:0]                     o_channel,
    output logic [6:0]                     o_note_number,
    output logic [6:0]                     o_velocity,
    output logic [31:0]                    o_abs_time,
    input  logic                           i_cfg_we,
    input  logic [mtep_pkg::LimitWidth-1:0] i_cfg_data
);

    mtep_pkg::t_phase r_phase, n_phase;
    logic [27:0] r_delta_accum, n_delta_accum;
    logic [31:0] r_time_total, n_time_total;
    logic [7:0]  r_status_hold, n_status_hold;
    logic [6:0]  r_first_data, n_first_data;
    logic [7:0]  r_skip_left, n_skip_left;
    logic [mtep_pkg::LimitWidth-1:0] r_events_sent, n_events_sent;
    logic [mtep_pkg::LimitWidth-1:0] r_event_limit;

    mtep_pkg::t_event r_out, r_skid, n_event;
    logic r_out_valid, r_skid_valid;
    logic accept, push;

    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;

    always_comb begin
        n_phase       = r_phase;
        n_delta_accum = r_delta_accum;
        n_time_total  = r_time_total;
        n_status_hold = r_status_hold;
        n_first_data  = r_first_data;
        n_skip_left   = r_skip_left;
        n_events_sent = r_events_sent;
        push          = 1'b0;

        n_event.event_kind  = ((r_status_hold[7:4] == mtep_pkg::NibbleNoteOff)
                               || (i_data_byte[6:0] == 7'd0))
                              ? mtep_pkg::EventNoteOff : mtep_pkg::EventNoteOn;
        n_event.channel     = r_status_hold[3:0];
        n_event.note_number = r_first_data;
        n_event.velocity    = i_data_byte[6:0];
        n_event.abs_time    = r_time_total;

        case (r_phase)
            mtep_pkg::PH_DELTA: begin
                n_delta_accum = {r_delta_accum[20:0], i_data_byte[6:0]};
                if (!i_data_byte[7]) begin
                    n_time_total  = r_time_total + {4'd0, n_delta_accum};
                    n_delta_accum = '0;
                    n_phase       = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS: begin
                if (i_data_byte < mtep_pkg::StatusFirst) begin
                    n_phase = mtep_pkg::PH_DELTA;
                end else if (i_data_byte < mtep_pkg::StatusOtherLo) begin
                    n_status_hold = i_data_byte;
                    n_phase       = mtep_pkg::PH_NOTE;
                end else if (i_data_byte < mtep_pkg::StatusSystem) begin
                    n_status_hold = i_data_byte;
                    n_skip_left   = ((i_data_byte[7:4] == mtep_pkg::NibbleProgram)
                                     || (i_data_byte[7:4] == mtep_pkg::NibblePress))
                                    ? 8'd1 : 8'd2;
                    n_phase       = mtep_pkg::PH_SKIP;
                end else if (i_data_byte == mtep_pkg::StatusMeta) begin
                    n_status_hold = i_data_byte;
                    n_phase       = mtep_pkg::PH_MTYPE;
                end else if ((i_data_byte == mtep_pkg::StatusSystem)
                             || (i_data_byte == mtep_pkg::StatusSysexEnd)) begin
                    n_status_hold = i_data_byte;
                    n_phase       = mtep_pkg::PH_LEN;
                end else begin
                    n_phase = mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_NOTE: begin
                n_first_data = i_data_byte[6:0];
                n_phase      = mtep_pkg::PH_VEL;
            end
            mtep_pkg::PH_VEL: begin
                // Note messages past the limit are parsed but produce no event.
                if (r_events_sent < r_event_limit) begin
                    push          = 1'b1;
                    n_events_sent = r_events_sent + mtep_pkg::CountOne;
                end
                n_phase = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_MTYPE: begin
                n_phase = mtep_pkg::PH_LEN;
            end
            mtep_pkg::PH_LEN: begin
                n_skip_left = i_data_byte;
                n_phase     = (i_data_byte == 8'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
            end
            mtep_pkg::PH_SKIP: begin
                n_skip_left = r_skip_left - 8'd1;
                if (r_skip_left == 8'd1) begin
                    n_phase = mtep_pkg::PH_DELTA;
                end
            end
            default: begin
                n_phase = mtep_pkg::PH_DELTA;
            end
        endcase

        if (i_last_byte) begin
            n_phase       = mtep_pkg::PH_DELTA;
            n_delta_accum = '0;
            n_time_total  = '0;
            n_status_hold = '0;
            n_first_data  = '0;
            n_skip_left   = '0;
            n_events_sent = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= mtep_pkg::PH_DELTA;
            r_delta_accum <= '0;
            r_time_total  <= '0;
            r_status_hold <= '0;
            r_first_data  <= '0;
            r_skip_left   <= '0;
            r_events_sent <= '0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_delta_accum <= n_delta_accum;
            r_time_total  <= n_time_total;
            r_status_hold <= n_status_hold;
            r_first_data  <= n_first_data;
            r_skip_left   <= n_skip_left;
            r_events_sent <= n_events_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_limit <= EVENT_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_event_limit <= i_cfg_data;
        end
    end

    // Result register with a skid register behind it; the skid fills only
    // when a new event arrives while the result register is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && i_stall) begin
            if (accept && push) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= accept && push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && i_stall) begin
            if (accept && push) begin
                r_skid <= n_event;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (accept && push) begin
            r_out <= n_event;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_event_kind  = r_out.event_kind;
    assign o_channel     = r_out.channel;
    assign o_note_number = r_out.note_number;
    assign o_velocity    = r_out.velocity;
    assign o_abs_time    = r_out.abs_time;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an event while the result register is empty");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mtep_pkg::PH_SKIP) |-> (r_skip_left != 8'd0))
        else $error("skipping with no bytes left to skip");

    a_track_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> ((r_phase == mtep_pkg::PH_DELTA)
                                     && (r_events_sent == '0) && (r_time_total == '0)))
        else $error("parser state not cleared after the last byte of a track");

    a_event_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && push && !i_last_byte)
        |=> (r_events_sent == $past(r_events_sent) + mtep_pkg::CountOne))
        else $error("emitted event not counted against the limit");

endmodule

[tb/sv/mtep_event_checker.sv]
`timescale 1ns / 1ps
// Scoreboard that predicts note events from accepted track bytes and checks the output channel.
module mtep_event_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_event_kind,
    input  logic [3:0]                      i_channel,
    input  logic [6:0]                      i_note_number,
    input  logic [6:0]                      i_velocity,
    input  logic [31:0]                     i_abs_time,
    input  logic                            i_cfg_we,
    input  logic [mtep_pkg::LimitWidth-1:0] i_cfg_data,
    output int                              o_pending,
    output int                              o_mismatches
);

    mtep_pkg::t_phase                parse_phase;
    logic [27:0]                     delta_accum;
    logic [31:0]                     time_total;
    logic [7:0]                      status_hold;
    logic [6:0]                      first_data;
    logic [7:0]                      skip_left;
    logic [15:0]                     events_sent;
    logic [mtep_pkg::LimitWidth-1:0] event_limit;
    mtep_pkg::t_event                expected_notes[$];
    int                              mismatch_count = 0;

    task automatic clear_parser();
        parse_phase = mtep_pkg::PH_DELTA;
        delta_accum = '0;
        time_total  = '0;
        status_hold = '0;
        first_data  = '0;
        skip_left   = '0;
        events_sent = '0;
    endtask

    // Advances the parser by one byte and queues the note event it produces, if any.
    task automatic parse_track_byte(input logic [7:0] b, input logic is_last);
        logic [6:0]       vel;
        mtep_pkg::t_event note;
        case (parse_phase)
            mtep_pkg::PH_DELTA: begin
                delta_accum = {delta_accum[20:0], b[6:0]};
                if (!b[7]) begin
                    time_total  = time_total + {4'b0, delta_accum};
                    delta_accum = '0;
                    parse_phase = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS: begin
                if (b < mtep_pkg::StatusFirst) begin
                    parse_phase = mtep_pkg::PH_DELTA;
                end else if (b < mtep_pkg::StatusOtherLo) begin
                    status_hold = b;
                    parse_phase = mtep_pkg::PH_NOTE;
                end else if (b < mtep_pkg::StatusSystem) begin
                    status_hold = b;
                    skip_left   = (b[7:4] == mtep_pkg::NibbleProgram
                                   || b[7:4] == mtep_pkg::NibblePress) ? 8'd1 : 8'd2;
                    parse_phase = mtep_pkg::PH_SKIP;
                end else if (b == mtep_pkg::StatusMeta) begin
                    status_hold = b;
                    parse_phase = mtep_pkg::PH_MTYPE;
                end else if (b == mtep_pkg::StatusSystem || b == mtep_pkg::StatusSysexEnd) begin
                    status_hold = b;
                    parse_phase = mtep_pkg::PH_LEN;
                end else begin
                    parse_phase = mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_NOTE: begin
                first_data  = b[6:0];
                parse_phase = mtep_pkg::PH_VEL;
            end
            mtep_pkg::PH_VEL: begin
                vel = b[6:0];
                if (events_sent < event_limit) begin
                    note.event_kind  = (status_hold[7:4] == mtep_pkg::NibbleNoteOff
                                        || vel == 7'd0) ?
                                       mtep_pkg::EventNoteOff : mtep_pkg::EventNoteOn;
                    note.channel     = status_hold[3:0];
                    note.note_number = first_data;
                    note.velocity    = vel;
                    note.abs_time    = time_total;
                    expected_notes.push_back(note);
                    events_sent = events_sent + 16'd1;
                end
                parse_phase = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_MTYPE: begin
                parse_phase = mtep_pkg::PH_LEN;
            end
            mtep_pkg::PH_LEN: begin
                skip_left   = b;
                parse_phase = (b == 8'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
            end
            mtep_pkg::PH_SKIP: begin
                skip_left = skip_left - 8'd1;
                if (skip_left == 8'd0) begin
                    parse_phase = mtep_pkg::PH_DELTA;
                end
            end
            default: begin
                parse_phase = mtep_pkg::PH_DELTA;
            end
        endcase
        // The end of a track wipes the parser but keeps the limit.
        if (is_last) begin
            clear_parser();
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        mtep_pkg::t_event want_note;
        if (!i_rst_n) begin
            clear_parser();
            event_limit = mtep_pkg::EventLimitReset;
            expected_notes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_notes.size() == 0) begin
                    $error("note event with none pending: kind %0d ch %0d note %0d vel %0d t %0d",
                           i_event_kind, i_channel, i_note_number, i_velocity, i_abs_time);
                    mismatch_count++;
                end else begin
                    want_note = expected_notes.pop_front();
                    check_field("event_kind", want_note.event_kind, i_event_kind);
                    check_field("channel", want_note.channel, i_channel);
                    check_field("note_number", want_note.note_number, i_note_number);
                    check_field("velocity", want_note.velocity, i_velocity);
                    check_field("abs_time", want_note.abs_time, i_abs_time);
                end
            end
            if (i_cfg_we) begin
                event_limit = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                parse_track_byte(i_data_byte, i_last_byte);
            end
        end
        o_pending    <= expected_notes.size();
        o_mismatches <= mismatch_count;
    end

endmodule

[tb/sv/tb_midi_track_event_parser.sv]
`timescale 1ns / 1ps
// Testbench top for the MIDI track event parser: stimulus, output stalls and verdict.
module tb_midi_track_event_parser;

    localparam logic [3:0] NibbleNoteOn    = 4'h9;
    localparam logic [3:0] NibblePolyPress = 4'hA;
    localparam logic [3:0] NibbleControl   = 4'hB;
    localparam logic [3:0] NibbleBend      = 4'hE;
    localparam logic [7:0] MetaTempo       = 8'h51;
    localparam logic [7:0] StatusClock     = 8'hF8;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_track_byte;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_valid       = 1'b0;
    logic                            o_stall;
    logic [7:0]                      i_data_byte   = 8'h00;
    logic                            i_last_byte   = 1'b0;
    logic                            o_valid;
    logic                            i_stall       = 1'b0;
    logic                            o_event_kind;
    logic [3:0]                      o_channel;
    logic [6:0]                      o_note_number;
    logic [6:0]                      o_velocity;
    logic [31:0]                     o_abs_time;
    logic                            i_cfg_we      = 1'b0;
    logic [mtep_pkg::LimitWidth-1:0] i_cfg_data    = '0;

    logic                  long_hold_req = 1'b0;
    int                    pending;
    int                    mismatches;
    t_track_byte           track_bytes[$];

    always #10 i_clk = ~i_clk;

    midi_track_event_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_event_kind  (o_event_kind),
        .o_channel     (o_channel),
        .o_note_number (o_note_number),
        .o_velocity    (o_velocity),
        .o_abs_time    (o_abs_time),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    mtep_event_checker note_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_event_kind  (o_event_kind),
        .i_channel     (o_channel),
        .i_note_number (o_note_number),
        .i_velocity    (o_velocity),
        .i_abs_time    (o_abs_time),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    task automatic push_byte(input logic [7:0] b, input logic is_last = 1'b0);
        t_track_byte item;
        item.data    = b;
        item.is_last = is_last;
        track_bytes.push_back(item);
    endtask

    // Mostly clean 7-bit data, now and then with the top bit set.
    function automatic logic [7:0] data_value();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(0, 7) != 0) begin
            v[7] = 1'b0;
        end
        return v;
    endfunction

    task automatic add_delta_time();
        int          n;
        logic [27:0] ticks;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                push_byte({1'b0, 7'($urandom)});
            end
            6, 7: begin
                n     = $urandom_range(2, 4);
                ticks = 28'($urandom);
                for (int i = n - 1; i > 0; i--) begin
                    push_byte({1'b1, ticks[7*i +: 7]});
                end
                push_byte({1'b0, ticks[6:0]});
            end
            8: begin
                repeat (3) push_byte(8'hFF);
                push_byte(8'h7F);
            end
            default: begin
                // Longer than four bytes: only the low 28 bits survive.
                repeat ($urandom_range(4, 5)) push_byte({1'b1, 7'($urandom)});
                push_byte({1'b0, 7'($urandom)});
            end
        endcase
    endtask

    task automatic add_track_message();
        int         len;
        logic [3:0] hi;
        logic [7:0] mtype;
        case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
                push_byte({mtep_pkg::NibbleNoteOff, 4'($urandom)});
                push_byte(data_value());
                push_byte(data_value());
            end
            4, 5, 6, 7, 8, 9: begin
                push_byte({NibbleNoteOn, 4'($urandom)});
                push_byte(data_value());
                push_byte(($urandom_range(0, 5) == 0) ? 8'h00 : data_value());
            end
            10, 11: begin
                case ($urandom_range(0, 2))
                    0:       hi = NibblePolyPress;
                    1:       hi = NibbleControl;
                    default: hi = NibbleBend;
                endcase
                push_byte({hi, 4'($urandom)});
                push_byte(data_value());
                push_byte(data_value());
            end
            12, 13: begin
                hi = ($urandom_range(0, 1) == 0) ? mtep_pkg::NibbleProgram
                                                 : mtep_pkg::NibblePress;
                push_byte({hi, 4'($urandom)});
                push_byte(data_value());
            end
            14: begin
                mtype = ($urandom_range(0, 1) == 0) ? MetaTempo : 8'($urandom);
                len   = (mtype == MetaTempo) ? 3 : $urandom_range(0, 6);
                push_byte(mtep_pkg::StatusMeta);
                push_byte(mtype);
                push_byte(8'(len));
                repeat (len) push_byte(8'($urandom));
            end
            15: begin
                len = $urandom_range(0, 8);
                push_byte(($urandom_range(0, 1) == 0) ? mtep_pkg::StatusSystem
                                                      : mtep_pkg::StatusSysexEnd);
                push_byte(8'(len));
                repeat (len) push_byte(8'($urandom));
            end
            16: begin
                mtype = 8'($urandom_range(32'hF1, 32'hFE));
                push_byte((mtype == mtep_pkg::StatusSysexEnd) ? StatusClock : mtype);
            end
            17: begin
                push_byte({1'b0, 7'($urandom)});
            end
            18: begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 255) : $urandom_range(7, 16);
                push_byte(mtep_pkg::StatusMeta);
                push_byte(8'($urandom));
                push_byte(8'(len));
                repeat (len) push_byte(8'($urandom));
            end
            default: begin
                push_byte(mtep_pkg::StatusMeta);
                push_byte(8'($urandom));
                push_byte(8'h00);
            end
        endcase
    endtask

    task automatic add_track(input int n_events, input logic ends);
        repeat (n_events) begin
            add_delta_time();
            add_track_message();
        end
        // Sometimes the track breaks off in the middle of a note message.
        if ($urandom_range(0, 4) == 0) begin
            add_delta_time();
            push_byte({NibbleNoteOn, 4'($urandom)});
        end
        if (ends) begin
            track_bytes[track_bytes.size() - 1].is_last = 1'b1;
        end
    endtask

    task automatic build_random(input int n_bytes);
        int target;
        target = track_bytes.size() + n_bytes;
        while (track_bytes.size() < target) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 12)) push_byte(8'($urandom), $urandom_range(0, 31) == 0);
            end else begin
                add_track($urandom_range(1, 16), $urandom_range(0, 4) != 0);
            end
        end
        // Leave a track open so that the next limit lands mid-track.
        add_track($urandom_range(2, 8), 1'b0);
    endtask

    task automatic drive_track_bytes();
        int          burst_left;
        int          gap;
        t_track_byte item;
        burst_left = 0;
        while (track_bytes.size() > 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = ($urandom_range(0, 3) == 0) ? 300 : $urandom_range(1, 24);
            end
            item = track_bytes.pop_front();
            i_valid     <= 1'b1;
            i_data_byte <= item.data;
            i_last_byte <= item.is_last;
            do @(posedge i_clk); while (o_stall);
            burst_left--;
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_until_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_limit_phase(input logic [mtep_pkg::LimitWidth-1:0] limit,
                                   input int n_bytes);
        wait_until_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        build_random(n_bytes);
        drive_track_bytes();
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed track under the reset limit.
        push_byte(8'h00); push_byte({NibbleNoteOn, 4'h0}); push_byte(8'h00); push_byte(8'h7F);
        push_byte(8'h81); push_byte(8'h00);
        push_byte({mtep_pkg::NibbleNoteOff, 4'hF}); push_byte(8'h7F); push_byte(8'h00);
        push_byte(8'h00); push_byte({NibbleNoteOn, 4'hA}); push_byte(8'hFF); push_byte(8'h80);
        push_byte(8'h00); push_byte(8'h45);
        push_byte(8'h00); push_byte({mtep_pkg::NibbleProgram, 4'h3}); push_byte(8'h10);
        push_byte(8'h00); push_byte(mtep_pkg::StatusMeta); push_byte(MetaTempo);
        push_byte(8'h00);
        push_byte(8'h00); push_byte(mtep_pkg::StatusSystem); push_byte(8'h01);
        push_byte(mtep_pkg::StatusSysexEnd);
        push_byte(8'h00); push_byte(StatusClock);
        repeat (4) push_byte(8'hFF);
        push_byte(8'h7F); push_byte({NibbleBend, 4'h1}); push_byte(8'h00); push_byte(8'h7F, 1'b1);
        drive_track_bytes();

        run_limit_phase(16'd0, 60);
        long_hold_req <= 1'b1;
        run_limit_phase(16'hFFFF, 320);
        run_limit_phase(16'd2, 200);
        run_limit_phase(16'd1, 120);
        run_limit_phase(16'($urandom_range(3, 40)), 240);

        wait_until_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[midi_track_event_parser] OK");
        end else begin
            $display("[midi_track_event_parser] ERROR");
        end
        $finish;
    end

    // Output back-pressure: random patterns, plus one long hold-off to fill the block.
    initial begin : receiver_pattern
        int   mode;
        int   run_len;
        int   cycle_ix;
        logic held_once;
        held_once = 1'b0;
        cycle_ix  = 0;
        forever begin
            if (long_hold_req && !held_once) begin
                held_once = 1'b1;
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end else begin
                mode    = $urandom_range(0, 3);
                run_len = $urandom_range(20, 200);
                repeat (run_len) begin
                    case (mode)
                        0:       i_stall <= 1'b0;
                        1:       i_stall <= ($urandom_range(0, 1) == 0);
                        2:       i_stall <= ($urandom_range(0, 7) != 0);
                        default: i_stall <= ((cycle_ix % 5) < 2);
                    endcase
                    cycle_ix++;
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        #(10_000_000);
        $display("[midi_track_event_parser] ERROR");
        $finish;
    end

endmodule
